// ----- rtl/sparse_fill_empty_rows_unit_macros.svh -----
// Assertion macros used by the checker file.
`ifndef SPARSE_FILL_EMPTY_ROWS_UNIT_MACROS_SVH
`define SPARSE_FILL_EMPTY_ROWS_UNIT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define SFER_ASSERT_IMP(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define SFER_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

// ----- rtl/sfer_pkg.sv -----
// Package with shared types and constants of the sparse fill unit.
`timescale 1ns / 1ps
package sfer_pkg;
  localparam int MaxRows    = 32;
  localparam int MaxEntries = 16;
  localparam int MaxRank    = 4;
  localparam int ValueBits  = 64;
  localparam int CoordBits  = 32;
  localparam int RowW       = 5;
  localparam int EntW       = 4;
  localparam int PosW       = 6;
  localparam int QDepth     = 4;

  localparam logic [1:0] KindSlot  = 2'd0;
  localparam logic [1:0] KindRmap  = 2'd1;
  localparam logic [1:0] KindError = 2'd2;
  localparam logic [1:0] KindNone  = 2'd3;

  localparam logic [1:0] StatBadRow  = 2'd0;
  localparam logic [1:0] StatNoRows  = 2'd1;
  localparam logic [1:0] StatTooMany = 2'd2;

  localparam logic [1:0] CfgRowTotal  = 2'd0;
  localparam logic [1:0] CfgIndexRank = 2'd1;
  localparam logic [1:0] CfgFillValue = 2'd2;

  // A classified word passed from front to back.
  typedef struct packed {
    logic                 finish;
    logic                 bad_row;
    logic [RowW-1:0]      row;
    logic [CoordBits-1:0] ca;
    logic [CoordBits-1:0] cb;
    logic [CoordBits-1:0] cc;
    logic [ValueBits-1:0] val;
  } cmd_t;

  // One result word.
  typedef struct packed {
    logic [1:0]           kind;
    logic [PosW-1:0]      position;
    logic [EntW-1:0]      entry_number;
    logic [RowW-1:0]      row;
    logic [CoordBits-1:0] ca;
    logic [CoordBits-1:0] cb;
    logic [CoordBits-1:0] cc;
    logic [ValueBits-1:0] val;
    logic                 filled;
    logic [1:0]           status;
    logic                 last;
  } res_t;
endpackage

// ----- rtl/sfer_front.sv -----
// Front end: checks rows, masks coordinates by rank and feeds the queue.
`timescale 1ns / 1ps
module sfer_front (
  input  logic [5:0]          row_total_i,
  input  logic [2:0]          index_rank_i,
  input  logic                command_i,
  input  logic [15:0]         entry_row_i,
  input  logic [31:0]         coord_a_i,
  input  logic [31:0]         coord_b_i,
  input  logic [31:0]         coord_c_i,
  input  logic [63:0]         value_i,
  output sfer_pkg::cmd_t      cmd_o
);
  logic [5:0] rows;
  logic [2:0] rank;
  always_comb begin
    rows = (row_total_i > 6'(sfer_pkg::MaxRows)) ? 6'(sfer_pkg::MaxRows) : row_total_i;
    rank = (index_rank_i == 3'd0) ? 3'd1 :
           (index_rank_i > 3'(sfer_pkg::MaxRank)) ? 3'(sfer_pkg::MaxRank) : index_rank_i;
    cmd_o.finish  = command_i;
    cmd_o.bad_row = (rows != 6'd0) && (entry_row_i[15] || (entry_row_i >= {10'd0, rows}));
    cmd_o.row     = entry_row_i[4:0];
    cmd_o.ca      = (rank > 3'd1) ? coord_a_i : '0;
    cmd_o.cb      = (rank > 3'd2) ? coord_b_i : '0;
    cmd_o.cc      = (rank > 3'd3) ? coord_c_i : '0;
    cmd_o.val     = value_i;
  end
endmodule

// ----- rtl/sfer_queue.sv -----
// Short queue between the front end and the back end.
`timescale 1ns / 1ps
module sfer_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  sfer_pkg::cmd_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output sfer_pkg::cmd_t data_o
);
  localparam int AW = $clog2(sfer_pkg::QDepth);
  sfer_pkg::cmd_t mem_q [sfer_pkg::QDepth];
  logic [AW-1:0] wp_q, rp_q;
  logic [AW:0]   cnt_q;
  assign full_o  = cnt_q == (AW+1)'(sfer_pkg::QDepth);
  assign empty_o = cnt_q == '0;
  assign data_o  = mem_q[rp_q];
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 1'b1;
      if (pop_i) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(push_i) - (AW+1)'(pop_i);
    end
  end
endmodule

// ----- rtl/sfer_back.sv -----
// Back end: stores entries, and on finish walks rows and entries to emit words.
`timescale 1ns / 1ps
module sfer_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [5:0]     row_total_i,
  input  logic [63:0]    fill_value_i,
  input  logic           empty_i,
  input  sfer_pkg::cmd_t cmd_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output sfer_pkg::res_t out_o
);
  localparam int EW = sfer_pkg::EntW;
  localparam int RW = sfer_pkg::RowW;
  localparam int PW = sfer_pkg::PosW;
  typedef enum logic [2:0] {
    S_LOAD, S_CHECK, S_ROW, S_ENT, S_RMAP, S_WAIT
  } state_e;

  state_e state_q;
  logic [EW:0]   loaded_q;
  logic          err_q;
  logic [1:0]    kind_q;
  logic [RW:0]   row_q;
  logic [EW:0]   ent_q;
  logic [PW-1:0] slot_q;
  logic          hit_q;
  logic [RW-1:0] rows_m [sfer_pkg::MaxEntries];
  logic [31:0]   ca_m [sfer_pkg::MaxEntries];
  logic [31:0]   cb_m [sfer_pkg::MaxEntries];
  logic [31:0]   cc_m [sfer_pkg::MaxEntries];
  logic [63:0]   val_m [sfer_pkg::MaxEntries];
  logic [PW-1:0] pos_m [sfer_pkg::MaxEntries];
  logic          ov_q;
  sfer_pkg::res_t out_q;
  logic [5:0]    rows;
  logic [EW-1:0] ei;
  logic          lastent;
  logic          fire;
  logic          emit;

  // Packs the fields of one result word.
  function automatic sfer_pkg::res_t mk_res(
    input logic [1:0]    kind,
    input logic [PW-1:0] pos,
    input logic [EW-1:0] ent,
    input logic [RW-1:0] row,
    input logic [31:0]   ca,
    input logic [31:0]   cb,
    input logic [31:0]   cc,
    input logic [63:0]   val,
    input logic          filled,
    input logic [1:0]    status,
    input logic          last
  );
    sfer_pkg::res_t r;
    r.kind         = kind;
    r.position     = pos;
    r.entry_number = ent;
    r.row          = row;
    r.ca           = ca;
    r.cb           = cb;
    r.cc           = cc;
    r.val          = val;
    r.filled       = filled;
    r.status       = status;
    r.last         = last;
    return r;
  endfunction

  assign rows = (row_total_i > 6'(sfer_pkg::MaxRows)) ? 6'(sfer_pkg::MaxRows) : row_total_i;
  assign ei = ent_q[EW-1:0];
  assign lastent = (ent_q + 1'b1) == loaded_q;
  assign out_valid_o = ov_q;
  assign out_o = out_q;
  assign fire = !ov_q || out_ready_i;
  assign pop_o = !empty_i && ((state_q == S_LOAD) &&
                 (!cmd_i.finish || !ov_q));

  // A new word enters the output register this cycle.
  always_comb begin
    emit = 1'b0;
    unique case (state_q)
      S_LOAD:  emit = pop_o && cmd_i.finish && ((rows == 6'd0) || err_q);
      S_CHECK: emit = fire && (ent_q < loaded_q) && ({1'b0, rows_m[ei]} >= rows);
      S_ENT:   emit = fire && ((ent_q >= loaded_q) ? !hit_q
                                                   : (rows_m[ei] == row_q[RW-1:0]));
      S_RMAP:  emit = fire && (ent_q < loaded_q);
      default: emit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && !cmd_i.finish && loaded_q < (EW+1)'(sfer_pkg::MaxEntries)) begin
      rows_m[loaded_q[EW-1:0]] <= cmd_i.row;
      ca_m[loaded_q[EW-1:0]]   <= cmd_i.ca;
      cb_m[loaded_q[EW-1:0]]   <= cmd_i.cb;
      cc_m[loaded_q[EW-1:0]]   <= cmd_i.cc;
      val_m[loaded_q[EW-1:0]]  <= cmd_i.val;
    end
    if (state_q == S_ENT && fire && ent_q < loaded_q &&
        rows_m[ei] == row_q[RW-1:0])
      pos_m[ei] <= slot_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (emit) begin
      ov_q <= 1'b1;
    end else if (out_ready_i) begin
      ov_q <= 1'b0;
    end
  end

  // Loads entries and, on finish, emits words into the output register and moves on.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD; loaded_q <= '0; err_q <= 1'b0; kind_q <= sfer_pkg::StatBadRow;
      row_q <= '0; ent_q <= '0; slot_q <= '0; hit_q <= 1'b0;
      out_q <= '0;
    end else begin
      unique case (state_q)
        S_LOAD: begin
          if (pop_o) begin
            if (!cmd_i.finish) begin
              if (loaded_q >= (EW+1)'(sfer_pkg::MaxEntries)) begin
                if (!err_q) begin err_q <= 1'b1; kind_q <= sfer_pkg::StatTooMany; end
              end else begin
                if (cmd_i.bad_row && !err_q) begin
                  err_q <= 1'b1; kind_q <= sfer_pkg::StatBadRow;
                end
                loaded_q <= loaded_q + 1'b1;
              end
            end else begin
              if (rows == 6'd0) begin
                out_q <= mk_res((loaded_q == '0) ? sfer_pkg::KindNone : sfer_pkg::KindError,
                                '0, '0, '0, '0, '0, '0, '0, 1'b0,
                                (loaded_q == '0) ? sfer_pkg::StatBadRow
                                                 : sfer_pkg::StatNoRows, 1'b1);
                state_q <= S_WAIT;
              end else if (err_q) begin
                out_q <= mk_res(sfer_pkg::KindError, '0, '0, '0, '0, '0, '0, '0, 1'b0,
                                kind_q, 1'b1);
                state_q <= S_WAIT;
              end else begin
                ent_q <= '0; state_q <= S_CHECK;
              end
            end
          end
        end
        S_CHECK: begin
          // Rows may have been lowered after loading; rescan one entry a cycle.
          if (ent_q >= loaded_q) begin
            row_q <= '0; ent_q <= '0; slot_q <= '0; hit_q <= 1'b0; state_q <= S_ROW;
          end else if ({1'b0, rows_m[ei]} >= rows) begin
            if (fire) begin
              out_q <= mk_res(sfer_pkg::KindError, '0, '0, '0, '0, '0, '0, '0, 1'b0,
                              sfer_pkg::StatBadRow, 1'b1);
              state_q <= S_WAIT;
            end
          end else begin
            ent_q <= ent_q + 1'b1;
          end
        end
        S_ROW: begin
          if ({1'b0, row_q} >= rows) begin
            ent_q <= '0; state_q <= S_RMAP;
          end else begin
            ent_q <= '0; hit_q <= 1'b0; state_q <= S_ENT;
          end
        end
        S_ENT: begin
          if (fire) begin
            if (ent_q >= loaded_q) begin
              if (!hit_q) begin
                out_q <= mk_res(sfer_pkg::KindSlot, slot_q, '0, row_q[RW-1:0], '0, '0, '0,
                                fill_value_i, 1'b1, '0,
                                ((row_q + 1'b1) == rows) && (loaded_q == '0));
                slot_q <= slot_q + 1'b1;
              end
              row_q <= row_q + 1'b1; state_q <= S_ROW;
            end else begin
              if (rows_m[ei] == row_q[RW-1:0]) begin
                out_q <= mk_res(sfer_pkg::KindSlot, slot_q, ei, row_q[RW-1:0], ca_m[ei],
                                cb_m[ei], cc_m[ei], val_m[ei], 1'b0, '0, 1'b0);
                slot_q <= slot_q + 1'b1; hit_q <= 1'b1;
              end
              ent_q <= ent_q + 1'b1;
            end
          end
        end
        S_RMAP: begin
          if (fire) begin
            if (ent_q >= loaded_q) begin
              state_q <= S_WAIT;
            end else begin
              out_q <= mk_res(sfer_pkg::KindRmap, pos_m[ei], ei, '0, '0, '0, '0, '0, 1'b0,
                              '0, lastent);
              ent_q <= ent_q + 1'b1;
            end
          end
        end
        S_WAIT: begin
          // Run is over once the final word has been queued; clear for the next run.
          loaded_q <= '0; err_q <= 1'b0; kind_q <= sfer_pkg::StatBadRow;
          state_q <= S_LOAD;
        end
        default: state_q <= S_LOAD;
      endcase
    end
  end
endmodule

// ----- rtl/sparse_fill_empty_rows_unit.sv -----
// Top level of the sparse fill unit: front end, queue and back end.
//  channel   dir  handshake               payload
//  s_axis    in   s_axis_tvalid/tready    tdata entry fields, tuser command
//  m_axis    out  m_axis_tvalid/tready    tdata result fields, tuser kind, tlast last
//  cfg       in   cfg_we_i                cfg_index_i, cfg_data_i
// Loads are taken one per cycle while the four-word queue has room.
// A finish first rechecks the rows of all loaded entries, then walks rows and entries
// to emit slot words, then emits reverse-map words and clears for the next run.
// Reset clears counters and state; entry stores have no reset.
// Either side may stall; during a finish walk the queue fills and input stalls.
`timescale 1ns / 1ps
module sparse_fill_empty_rows_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_index_i,
  input  logic [63:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // entry_row[15:0], entry_coord_a[47:16], entry_coord_b[79:48], entry_coord_c[111:80],
  // entry_value[175:112]
  input  logic [175:0] s_axis_tdata,
  // command[0]
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // position[5:0], entry_number[9:6], out_row[14:10], out_coord_a[46:15],
  // out_coord_b[78:47], out_coord_c[110:79], out_value[174:111], filled_default[175],
  // status[177:176], zero[183:178]
  output logic [183:0] m_axis_tdata,
  // kind[1:0]
  output logic [1:0]   m_axis_tuser,
  output logic         m_axis_tlast
);
  logic [5:0]  row_total_q;
  logic [2:0]  index_rank_q;
  logic [63:0] fill_value_q;
  sfer_pkg::cmd_t cmd_in, cmd_out;
  sfer_pkg::res_t res;
  logic full, empty, pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_total_q <= '0; index_rank_q <= 3'd2; fill_value_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        sfer_pkg::CfgRowTotal:  row_total_q  <= cfg_data_i[5:0];
        sfer_pkg::CfgIndexRank: index_rank_q <= cfg_data_i[2:0];
        sfer_pkg::CfgFillValue: fill_value_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign s_axis_tready = !full;

  sfer_front u_front (
    .row_total_i(row_total_q), .index_rank_i(index_rank_q), .command_i(s_axis_tuser),
    .entry_row_i(s_axis_tdata[15:0]), .coord_a_i(s_axis_tdata[47:16]),
    .coord_b_i(s_axis_tdata[79:48]), .coord_c_i(s_axis_tdata[111:80]),
    .value_i(s_axis_tdata[175:112]), .cmd_o(cmd_in)
  );

  sfer_queue u_queue (
    .clk_i, .rst_ni, .push_i(s_axis_tvalid && !full), .data_i(cmd_in), .full_o(full),
    .pop_i(pop), .empty_o(empty), .data_o(cmd_out)
  );

  sfer_back u_back (
    .clk_i, .rst_ni, .row_total_i(row_total_q), .fill_value_i(fill_value_q),
    .empty_i(empty), .cmd_i(cmd_out), .pop_o(pop), .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready), .out_o(res)
  );

  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;
  assign m_axis_tdata = {6'd0, res.status, res.filled, res.val, res.cc, res.cb, res.ca,
                         res.row, res.entry_number, res.position};
endmodule

// ----- rtl/sparse_fill_empty_rows_unit_checker.sv -----
// Port-level checker for the sparse fill unit, bound to the top level.
`timescale 1ns / 1ps
`include "sparse_fill_empty_rows_unit_macros.svh"
module sparse_fill_empty_rows_unit_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [183:0] m_axis_tdata,
  input logic [1:0]   m_axis_tuser,
  input logic         m_axis_tlast
);
  logic         stall;
  logic         ends_run;
  logic         fill_word;
  logic         plain_word;
  logic [186:0] word_bits;

  assign stall      = m_axis_tvalid && !m_axis_tready;
  assign ends_run   = m_axis_tvalid && ((m_axis_tuser == sfer_pkg::KindError) ||
                                        (m_axis_tuser == sfer_pkg::KindNone));
  assign fill_word  = m_axis_tvalid && m_axis_tdata[175];
  assign plain_word = m_axis_tvalid && (m_axis_tuser != sfer_pkg::KindError);
  assign word_bits  = {m_axis_tlast, m_axis_tuser, m_axis_tdata};

  `SFER_ASSERT_NEXT(a_hold, clk_i, rst_ni, stall, m_axis_tvalid && $stable(word_bits))
  `SFER_ASSERT_IMP(a_err_last, clk_i, rst_ni, ends_run, m_axis_tlast)
  `SFER_ASSERT_IMP(a_fill_slot, clk_i, rst_ni, fill_word, m_axis_tuser == sfer_pkg::KindSlot)
  `SFER_ASSERT_IMP(a_stat_err, clk_i, rst_ni, plain_word, m_axis_tdata[177:176] == 2'd0)
endmodule

bind sparse_fill_empty_rows_unit sparse_fill_empty_rows_unit_checker u_checker (.*);
